// ===== rtl/spiral_matrix_readout_defines.svh =====
// Assertion macros shared by the spiral matrix readout modules.
`ifndef SPIRAL_MATRIX_READOUT_DEFINES_SVH
`define SPIRAL_MATRIX_READOUT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smr_pkg.sv =====
// Types and constants shared by the spiral matrix readout modules.
package smr_pkg;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CFG_ROW_COUNT = 1'b0;
  localparam cfg_index_t CFG_COL_COUNT = 1'b1;

  localparam int          CFG_WIDTH       = 5;
  localparam logic [4:0]  CFG_COUNT_RESET = 5'd16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] elem_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic               is_last;
    logic               exhausted;
  } result_t;

  typedef struct packed {
    logic load_wr;   // store the accepted element
    logic rd_start;  // read transaction accepted
    logic step;      // form the index and advance the walk
    logic mem_rd;    // read the store at the registered index
    logic out_load;  // move the fetched element into the result register
  } smr_cmd_t;

  typedef struct packed {
    logic item_is_read;
  } smr_status_t;

endpackage

// ===== rtl/smr_ctrl.sv =====
// Controller: sequences each read transaction and owns the result handshake.
`include "spiral_matrix_readout_defines.svh"

module smr_ctrl
  import smr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        result_ready,
  output logic        result_valid,
  input  smr_status_t status,
  output smr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INDEX,
    ST_FETCH,
    ST_RESULT
  } state_t;

  state_t state;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load_wr  = item_valid && item_ready && !status.item_is_read;
    cmd.rd_start = item_valid && item_ready && status.item_is_read;
    cmd.step     = (state == ST_INDEX);
    cmd.mem_rd   = (state == ST_FETCH);
    cmd.out_load = (state == ST_RESULT) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.rd_start) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SMR_ASSERT_NEXT(a_read_steps, clk, rst, cmd.rd_start, cmd.step, "read did not step the walk")
  `SMR_ASSERT_NEXT(a_step_fetch, clk, rst, cmd.step, cmd.mem_rd, "step not followed by fetch")
  `SMR_ASSERT_NEXT(a_out_shown, clk, rst, cmd.out_load, result_valid, "loaded result not shown")

endmodule

// ===== rtl/smr_datapath.sv =====
// Datapath: size registers, element store, spiral walk counters and result register.
`include "spiral_matrix_readout_defines.svh"

module smr_datapath
  import smr_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  cfg_index_t           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  item_t                item,
  input  smr_cmd_t             cmd,
  output smr_status_t          status,
  output result_t              result
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DW    = $clog2(MAXD + 1);
  localparam int BW    = $clog2(MAXD) + 2;
  localparam int RST_ROWS = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int RST_COLS = (MAX_COLS < 16) ? MAX_COLS : 16;

  localparam logic signed [BW-1:0] ONE  = BW'(1);
  localparam logic signed [BW-1:0] ZERO = '0;

  typedef enum logic [2:0] {
    PH_TOP,
    PH_RIGHT,
    PH_BOTTOM,
    PH_LEFT,
    PH_COLUMN,
    PH_ROW,
    PH_DONE
  } phase_t;

  function automatic phase_t ring_phase(input logic signed [BW-1:0] t,
                                        input logic signed [BW-1:0] b,
                                        input logic signed [BW-1:0] l,
                                        input logic signed [BW-1:0] r);
    phase_t ph;
    if (l < r && t < b) begin
      ph = PH_TOP;
    end else if (l == r) begin
      ph = PH_COLUMN;
    end else if (t == b) begin
      ph = PH_ROW;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  // Size registers
  logic [CFG_WIDTH-1:0] row_count;
  logic [CFG_WIDTH-1:0] col_count;
  logic [DW-1:0]        eff_rows;
  logic [DW-1:0]        eff_cols;
  logic [2*DW-1:0]      total_full;
  logic [CW-1:0]        total;
  logic signed [BW-1:0] rows_s;
  logic signed [BW-1:0] cols_s;

  // Load side
  logic [CW-1:0] load_index;
  logic [CW-1:0] load_base;
  logic          load_take;
  logic          reading;

  // Walk state
  phase_t               phase;
  phase_t               phase_next;
  phase_t               ring_next;
  logic signed [BW-1:0] top_b, bot_b, left_b, right_b, walk_pos;
  logic signed [BW-1:0] top_next, bot_next, left_next, right_next, walk_next;
  logic signed [BW-1:0] walk_inc, walk_dec;
  logic signed [BW-1:0] r_sel, c_sel;
  logic [CW-1:0]        emitted_count;
  logic [CW-1:0]        emitted_inc;
  logic                 exh_now;
  logic                 emit_step;

  // Index and fetch
  logic [BW+DW-1:0] r_ext, c_ext, cols_ext, idx_full;
  logic [BW+3:0]    r_wide, c_wide;
  logic [AW-1:0]    addr_q;
  logic [3:0]       row_q, col_q;
  logic             exh_q, last_q;
  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data;

  assign status.item_is_read = (item.func == FUNC_READ);

  assign eff_rows   = (int'(row_count) > MAX_ROWS) ? DW'(MAX_ROWS) : DW'(row_count);
  assign eff_cols   = (int'(col_count) > MAX_COLS) ? DW'(MAX_COLS) : DW'(col_count);
  assign total_full = {{DW{1'b0}}, eff_rows} * {{DW{1'b0}}, eff_cols};
  assign total      = CW'(total_full);
  assign rows_s     = BW'(eff_rows);
  assign cols_s     = BW'(eff_cols);

  // A load after reads starts a new matrix at element zero.
  assign load_base = reading ? '0 : load_index;
  assign load_take = cmd.load_wr && (load_base < total);

  assign walk_inc    = walk_pos + ONE;
  assign walk_dec    = walk_pos - ONE;
  assign emitted_inc = emitted_count + CW'(1);
  assign exh_now     = (total == '0) || (emitted_count >= total) || (phase == PH_DONE);
  assign emit_step   = cmd.step && !exh_now;

  assign top_next   = top_b + ONE;
  assign bot_next   = bot_b - ONE;
  assign left_next  = left_b + ONE;
  assign right_next = right_b - ONE;
  assign ring_next  = ring_phase(top_next, bot_next, left_next, right_next);

  always_comb begin
    phase_next = phase;
    walk_next  = walk_inc;
    r_sel      = top_b;
    c_sel      = walk_pos;
    case (phase)
      PH_TOP: begin
        if (walk_inc == right_b) begin
          phase_next = PH_RIGHT;
          walk_next  = top_b;
        end
      end
      PH_RIGHT: begin
        r_sel = walk_pos;
        c_sel = right_b;
        if (walk_inc == bot_b) begin
          phase_next = PH_BOTTOM;
          walk_next  = right_b;
        end
      end
      PH_BOTTOM: begin
        r_sel     = bot_b;
        walk_next = walk_dec;
        if (walk_dec == left_b) begin
          phase_next = PH_LEFT;
          walk_next  = bot_b;
        end
      end
      PH_LEFT: begin
        r_sel     = walk_pos;
        c_sel     = left_b;
        walk_next = walk_dec;
        if (walk_dec == top_b) begin
          phase_next = ring_next;
          walk_next  = (ring_next == PH_COLUMN) ? top_next : left_next;
        end
      end
      PH_COLUMN: begin
        r_sel = walk_pos;
        c_sel = left_b;
        if (walk_inc > bot_b) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
        if (walk_inc > right_b) begin
          phase_next = PH_DONE;
        end
      end
    endcase
  end

  assign r_ext    = {{DW{1'b0}}, r_sel};
  assign c_ext    = {{DW{1'b0}}, c_sel};
  assign cols_ext = {{BW{1'b0}}, eff_cols};
  assign idx_full = r_ext * cols_ext + c_ext;
  assign r_wide   = {4'b0000, r_sel};
  assign c_wide   = {4'b0000, c_sel};

  // Size registers and load pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= CFG_COUNT_RESET;
      col_count  <= CFG_COUNT_RESET;
      load_index <= '0;
      reading    <= 1'b0;
    end else begin
      if (cmd.load_wr) begin
        reading    <= 1'b0;
        load_index <= load_take ? (load_base + CW'(1)) : load_base;
      end
      if (cmd.rd_start) begin
        reading <= 1'b1;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_ROW_COUNT: row_count <= cfg_data;
          CFG_COL_COUNT: col_count <= cfg_data;
          default: ;
        endcase
        load_index <= '0;
        reading    <= 1'b0;
      end
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TOP;
      top_b         <= ZERO;
      bot_b         <= BW'(RST_ROWS - 1);
      left_b        <= ZERO;
      right_b       <= BW'(RST_COLS - 1);
      walk_pos      <= ZERO;
      emitted_count <= '0;
    end else if (cmd.rd_start && !reading) begin
      phase         <= ring_phase(ZERO, rows_s - ONE, ZERO, cols_s - ONE);
      top_b         <= ZERO;
      bot_b         <= rows_s - ONE;
      left_b        <= ZERO;
      right_b       <= cols_s - ONE;
      walk_pos      <= ZERO;
      emitted_count <= '0;
    end else if (emit_step) begin
      phase         <= phase_next;
      walk_pos      <= walk_next;
      emitted_count <= emitted_inc;
      if (phase == PH_LEFT && walk_dec == top_b) begin
        top_b   <= top_next;
        bot_b   <= bot_next;
        left_b  <= left_next;
        right_b <= right_next;
      end
    end
  end

  // Registered index and per-result flags
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      addr_q <= AW'(idx_full);
      row_q  <= r_wide[3:0];
      col_q  <= c_wide[3:0];
      exh_q  <= exh_now;
      last_q <= !exh_now && (emitted_inc == total);
    end
  end

  // Element store
  always_ff @(posedge clk) begin
    if (load_take) begin
      mem[load_base[AW-1:0]] <= item.elem_value;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr_q];
    end
  end

  // Result register; an exhausted read returns zeros.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_value <= exh_q ? '0 : rd_data;
      result.out_row   <= exh_q ? '0 : row_q;
      result.out_col   <= exh_q ? '0 : col_q;
      result.is_last   <= last_q;
      result.exhausted <= exh_q;
    end
  end

  `SMR_ASSERT_NOW(a_load_bound, clk, rst, 1'b1, load_index <= total, "load pointer past matrix")
  `SMR_ASSERT_NOW(a_emit_bound, clk, rst, reading, emitted_count <= total, "walk emitted too many")
  `SMR_ASSERT_NEXT(a_emit_inc, clk, rst, emit_step, emitted_count == $past(emitted_inc), "walk stuck")

endmodule

// ===== rtl/spiral_matrix_readout.sv =====
// Top level of the spiral matrix readout: controller plus datapath.
//
//   channel   direction  handshake                payload
//   cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//   item      in         item_valid / item_ready  item (func, elem_value)
//   result    out        result_valid / result_ready  result
//
// A load is written to the store as it is accepted, and another load can follow it in the next cycle.
// A read passes through accept, index register, store read and result register, in that order.
// A pending result does not hold off the next item, but a read reaching the
// result register waits there until the pending result is taken.
// Synchronous reset clears control state only; the store has no clearing pass.
// Configuration writes are taken in any cycle (cfg_ready stays high).

module spiral_matrix_readout
  import smr_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_index_t           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  smr_cmd_t    cmd;
  smr_status_t status;

  assign cfg_ready = 1'b1;

  smr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .status       (status),
    .cmd          (cmd)
  );

  smr_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the spiral matrix readout block.
`timescale 1ns / 1ps

module tb
  import smr_pkg::*;
();

  localparam int GRID_MAX = 16;
  localparam int SETTLE_CYCLES = 8;

  typedef enum {
    SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT, SIDE_COLUMN, SIDE_ROW, SIDE_DONE
  } walk_side_t;

  typedef enum {SHAPE_CLEAN, SHAPE_RESTART, SHAPE_NOISE, SHAPE_PARTIAL} phase_shape_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  // Scoreboard: tracks the stored matrix and the spiral walk, queues the results awaited.
  class spiral_scoreboard_t;
    logic [31:0] cells [GRID_MAX*GRID_MAX];
    bit          cell_written [GRID_MAX*GRID_MAX];
    int          row_reg, col_reg;
    int          load_ptr;
    bit          reading;
    walk_side_t  side;
    int          top_b, bottom_b, left_b, right_b, pos, emitted;
    result_t     awaited_reads [$];
    int          mismatches;

    function new();
      row_reg = int'(CFG_COUNT_RESET);
      col_reg = int'(CFG_COUNT_RESET);
      load_ptr = 0;
      reading = 1'b0;
      mismatches = 0;
      foreach (cell_written[i]) cell_written[i] = 1'b0;
      begin_walk();
      side = SIDE_TOP;
    endfunction

    function void queue_result(result_t r);
      awaited_reads = {awaited_reads, r};
    endfunction

    function int rows_used();
      return row_reg > GRID_MAX ? GRID_MAX : row_reg;
    endfunction

    function int cols_used();
      return col_reg > GRID_MAX ? GRID_MAX : col_reg;
    endfunction

    function int total_cells();
      return rows_used() * cols_used();
    endfunction

    function void start_ring();
      if (left_b < right_b && top_b < bottom_b) begin
        side = SIDE_TOP;
        pos = left_b;
      end else if (left_b == right_b) begin
        side = SIDE_COLUMN;
        pos = top_b;
      end else if (top_b == bottom_b) begin
        side = SIDE_ROW;
        pos = left_b;
      end else begin
        side = SIDE_DONE;
      end
    endfunction

    function void begin_walk();
      top_b = 0;
      bottom_b = rows_used() - 1;
      left_b = 0;
      right_b = cols_used() - 1;
      pos = 0;
      emitted = 0;
      start_ring();
    endfunction

    function void current_cell(output int r, output int c);
      case (side)
        SIDE_TOP: begin
          r = top_b; c = pos;
        end
        SIDE_RIGHT: begin
          r = pos; c = right_b;
        end
        SIDE_BOTTOM: begin
          r = bottom_b; c = pos;
        end
        SIDE_LEFT, SIDE_COLUMN: begin
          r = pos; c = left_b;
        end
        default: begin
          r = top_b; c = pos;
        end
      endcase
    endfunction

    function bit walk_exhausted();
      return total_cells() == 0 || emitted >= total_cells() || side == SIDE_DONE;
    endfunction

    // A read may only touch cells that some load has filled since reset.
    function bit read_is_safe();
      int r, c;
      if (!reading) return total_cells() == 0 || cell_written[0];
      if (walk_exhausted()) return 1'b1;
      current_cell(r, c);
      return cell_written[r * cols_used() + c];
    endfunction

    function void set_count(cfg_index_t idx, logic [4:0] value);
      if (idx == CFG_ROW_COUNT) row_reg = int'(value);
      else col_reg = int'(value);
      load_ptr = 0;
      reading = 1'b0;
      begin_walk();
    endfunction

    function void note_item(item_t x);
      int r, c, idx;
      result_t want;
      if (x.func == FUNC_LOAD) begin
        if (reading) begin
          reading = 1'b0;
          load_ptr = 0;
        end
        if (load_ptr < total_cells()) begin
          cells[load_ptr] = x.elem_value;
          cell_written[load_ptr] = 1'b1;
          load_ptr++;
        end
        return;
      end
      if (!reading) begin
        reading = 1'b1;
        begin_walk();
      end
      want = '0;
      if (walk_exhausted()) begin
        want.exhausted = 1'b1;
        queue_result(want);
        return;
      end
      current_cell(r, c);
      case (side)
        SIDE_TOP: begin
          pos++;
          if (pos == right_b) begin
            side = SIDE_RIGHT;
            pos = top_b;
          end
        end
        SIDE_RIGHT: begin
          pos++;
          if (pos == bottom_b) begin
            side = SIDE_BOTTOM;
            pos = right_b;
          end
        end
        SIDE_BOTTOM: begin
          pos--;
          if (pos == left_b) begin
            side = SIDE_LEFT;
            pos = bottom_b;
          end
        end
        SIDE_LEFT: begin
          pos--;
          // shrink to the next ring
          if (pos == top_b) begin
            top_b++; left_b++; bottom_b--; right_b--;
            start_ring();
          end
        end
        SIDE_COLUMN: begin
          pos++;
          if (pos > bottom_b) side = SIDE_DONE;
        end
        default: begin
          pos++;
          if (pos > right_b) side = SIDE_DONE;
        end
      endcase
      idx = r * cols_used() + c;
      emitted++;
      want.out_value = cells[idx];
      want.out_row = r[3:0];
      want.out_col = c[3:0];
      want.is_last = (emitted == total_cells());
      queue_result(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_reads.size() == 0) begin
        report("result with none awaited", got.out_value, 32'h0);
        return;
      end
      want = awaited_reads.pop_front();
      if (got.out_value !== want.out_value) report("out_value", got.out_value, want.out_value);
      if (got.out_row !== want.out_row)
        report("out_row", 32'(got.out_row), 32'(want.out_row));
      if (got.out_col !== want.out_col)
        report("out_col", 32'(got.out_col), 32'(want.out_col));
      if (got.is_last !== want.is_last)
        report("is_last", 32'(got.is_last), 32'(want.is_last));
      if (got.exhausted !== want.exhausted)
        report("exhausted", 32'(got.exhausted), 32'(want.exhausted));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_index_t           cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic                 item_valid;
  logic                 item_ready;
  item_t                item;
  logic                 result_valid;
  logic                 result_ready;
  result_t              result;

  spiral_scoreboard_t sb;
  int                 items_sent;
  int                 burst_left;
  bit                 steady;
  int                 rx_cycle;
  rx_pattern_t        rx_pattern;

  spiral_matrix_readout dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL spiral_matrix_readout");
    $finish;
  end

  // Receiver stalls: switch among open, coin-flip, sparse and periodic ready patterns.
  always @(posedge clk) begin
    if (rx_cycle % 64 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_pattern)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:   result_ready <= (rx_cycle % 8) > 2;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  task automatic hold_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_reads.size() != 0) @(posedge clk);
  endtask

  // Let trailing reads return their results before touching the registers.
  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        if ($urandom_range(0, 30) == 0) begin
          hold_for_results();
        end else begin
          int gap;
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
  endtask

  task automatic send(logic f, logic [31:0] v);
    item_t x;
    int    next_slot;
    if (f == FUNC_READ && !sb.read_is_safe()) f = FUNC_LOAD;
    next_slot = sb.reading ? 0 : sb.load_ptr;
    // dropped loads do not count
    if (f == FUNC_READ || next_slot < sb.total_cells()) items_sent++;
    x.func = f;
    x.elem_value = v;
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(x);
    pace();
  endtask

  task automatic write_counts(logic [4:0] rows, logic [4:0] cols);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data <= rows;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(CFG_ROW_COUNT, rows);
    cfg_index <= CFG_COL_COUNT;
    cfg_data <= cols;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(CFG_COL_COUNT, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [4:0] rows, logic [4:0] cols, phase_shape_t shape);
    int total, n_load, n_read;
    settle();
    write_counts(rows, cols);
    steady = ($urandom_range(0, 3) == 0);
    total = sb.total_cells();
    case (shape)
      SHAPE_CLEAN: begin
        n_load = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n_load) send(FUNC_LOAD, $urandom);
        n_read = total + $urandom_range(0, 2);
        repeat (n_read) send(FUNC_READ, $urandom);
      end
      SHAPE_RESTART: begin
        repeat (total) send(FUNC_LOAD, $urandom);
        n_read = $urandom_range(1, total + 1);
        repeat (n_read) send(FUNC_READ, $urandom);
        // a load now starts a fresh matrix
        repeat (total) send(FUNC_LOAD, $urandom);
        repeat (total + 1) send(FUNC_READ, $urandom);
      end
      SHAPE_NOISE: begin
        n_load = (2 * total + 4 < 60) ? 2 * total + 4 : 60;
        repeat (n_load) send(1'($urandom_range(0, 1)), $urandom);
      end
      default: begin
        n_load = $urandom_range(0, total < 64 ? total : 64);
        repeat (n_load) send(FUNC_LOAD, $urandom);
        n_read = $urandom_range(1, total < 24 ? total + 1 : 24);
        repeat (n_read) send(FUNC_READ, $urandom);
      end
    endcase
  endtask

  function automatic logic [4:0] pick_count();
    int k;
    k = $urandom_range(0, 11);
    if (k == 0) return 5'd0;
    if (k == 1) return 5'($urandom_range(16, 31));
    return 5'($urandom_range(1, 5));
  endfunction

  initial begin
    logic [4:0]   rows, cols;
    phase_shape_t shape;
    int           k;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    rx_cycle = 0;
    items_sent = 0;
    burst_left = 4;
    steady = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Two by three: one full ring covers all six elements, extreme values.
    write_counts(5'd2, 5'd3);
    send(FUNC_LOAD, 32'h8000_0000);
    send(FUNC_LOAD, 32'h7fff_ffff);
    send(FUNC_LOAD, 32'h0000_0000);
    send(FUNC_LOAD, 32'hffff_ffff);
    send(FUNC_LOAD, 32'h5555_5555);
    send(FUNC_LOAD, 32'haaaa_aaaa);
    repeat (3) send(FUNC_READ, $urandom);
    hold_for_results();
    repeat (4) send(FUNC_READ, $urandom);

    // Empty matrix: load dropped, read exhausted.
    settle();
    write_counts(5'd0, 5'd5);
    send(FUNC_LOAD, 32'h1234_5678);
    send(FUNC_READ, $urandom);

    // Single row, then single column.
    settle();
    write_counts(5'd1, 5'd2);
    send(FUNC_LOAD, $urandom);
    send(FUNC_LOAD, $urandom);
    repeat (2) send(FUNC_READ, $urandom);
    settle();
    write_counts(5'd2, 5'd1);
    send(FUNC_LOAD, $urandom);
    send(FUNC_LOAD, $urandom);
    repeat (2) send(FUNC_READ, $urandom);

    // Largest sizes and oversized counts.
    run_phase(5'd16, 5'd16, SHAPE_PARTIAL);
    run_phase(5'd31, 5'd1, SHAPE_CLEAN);
    run_phase(5'd1, 5'd17, SHAPE_CLEAN);

    while (items_sent < 385) begin
      rows = pick_count();
      cols = pick_count();
      if (rows > 5'd5) cols = 5'($urandom_range(0, 2));
      k = $urandom_range(0, 9);
      if (k < 5) shape = SHAPE_CLEAN;
      else if (k < 7) shape = SHAPE_RESTART;
      else if (k < 9) shape = SHAPE_NOISE;
      else shape = SHAPE_PARTIAL;
      run_phase(rows, cols, shape);
    end

    hold_for_results();
    repeat (10) @(posedge clk);
    if (sb.awaited_reads.size() != 0)
      sb.report("results never returned", sb.awaited_reads.size(), 32'h0);
    if (sb.mismatches == 0) begin
      $display("PASS spiral_matrix_readout");
    end else begin
      $display("FAIL spiral_matrix_readout");
    end
    $finish;
  end

endmodule
